### src/gfe_pkg.sv
// ----------------------------------------------------------------------------
// Gray framebuffer engine package
// Shared payload types, action codes and fixed widths of the 2 bpp engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gfe_pkg;

  localparam int unsigned DIM_W = 11;
  localparam int unsigned PIX_W = 2 * DIM_W;
  localparam int unsigned CNT_W = PIX_W - 1;

  localparam logic [2:0] ACT_SET  = 3'd0;
  localparam logic [2:0] ACT_GET  = 3'd1;
  localparam logic [2:0] ACT_FILL = 3'd2;
  localparam logic [2:0] ACT_RECT = 3'd3;
  localparam logic [2:0] ACT_SCAN = 3'd4;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [7:0] GRAY_MASK = 8'h55;

  typedef struct packed {
    logic [2:0]       action;
    logic [9:0]       pos_x;
    logic [9:0]       pos_y;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [2:0]       gray_level;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] read_level;
    logic       has_gray;
  } result_t;

endpackage

`default_nettype wire

### src/gfe_stream_if.sv
// ----------------------------------------------------------------------------
// Gray framebuffer engine stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/gfe_ram.sv
// ----------------------------------------------------------------------------
// Gray framebuffer engine RAM
// Single-port memory with one write or read per cycle and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### src/gray2_framebuffer_engine_core.sv
// ----------------------------------------------------------------------------
// Gray framebuffer engine core
// Packed 2 bpp gray framebuffer with set, get, fill, rectangle and scan.
// ----------------------------------------------------------------------------
// Each action arrives as one transfer on item_i and answers with exactly one
// transfer on result_o. The frame size is programmed over the APB port
// (frame_width at byte address 0, frame_height at byte address 4); the user
// must write it only while the engine is idle, which the block does not
// enforce. item_i is ready only when the sequencer is idle, so one action
// is worked on at a time; one shared multiplier forms the frame area and
// then the pixel index, and the single memory port sets the pace. A rejected
// action goes to the result after the check; set reads and rewrites one
// byte, get reads one, a fill writes each used byte, a rectangle rewrites
// each pixel and a scan stops at the first intermediate gray byte.
// The result sits in an output register; the next action may be accepted
// while it waits, and a stalled receiver only holds the engine once a second
// result is ready. Reset clears the frame size and the control state; the
// store itself is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module gray2_framebuffer_engine_core #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned STORE_BYTES = 262144
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gfe_stream_if.sink       item_i,
  gfe_stream_if.source     result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned DW = gfe_pkg::DIM_W;
  localparam int unsigned PW = gfe_pkg::PIX_W;
  localparam int unsigned CW = gfe_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_PX_RD,
    S_PX_WR,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  state_e            state_q;
  gfe_pkg::item_t    item_q;
  gfe_pkg::result_t  res_q;
  logic              out_valid_q;
  logic              acc_q;
  logic [1:0]        lvl_rd_q;
  logic              gray_q;
  logic [DW-1:0]     frame_w_q;
  logic [DW-1:0]     frame_h_q;
  logic [PW-1:0]     area_q;
  logic [PW-1:0]     pixel_q;
  logic [PW-1:0]     row_start_q;
  logic [DW-1:0]     col_q;
  logic [DW-1:0]     row_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     used_q;

  logic              cfg_write;
  logic              item_fire;
  logic [DW-1:0]     mul_a;
  logic [PW-1:0]     mul_p;
  logic [CW-1:0]     used_w;
  logic              frame_ok;
  logic              lvl_ok;
  logic              in_frame;
  logic              rect_ok;
  logic              act_ok;
  state_e            act_next;
  logic [1:0]        lvl;
  logic [2:0]        shift;
  logic [7:0]        pix_mask;
  logic [7:0]        fill_pattern;
  logic              last_col;
  logic              last_row;
  logic              byte_gray;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // Configuration port.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == gfe_pkg::CFG_FRAME_HEIGHT) ?
                     32'(frame_h_q) : 32'(frame_w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= '0;
      frame_h_q <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == gfe_pkg::CFG_FRAME_WIDTH) begin
        frame_w_q <= pwdata[DW-1:0];
      end else begin
        frame_h_q <= pwdata[DW-1:0];
      end
    end
  end

  // Shared multiplier: frame area first, then the pixel row offset.
  assign mul_a = (state_q == S_CHECK) ? frame_h_q : DW'(item_q.pos_y);
  assign mul_p = PW'(mul_a) * PW'(frame_w_q);

  assign used_w   = CW'((area_q + PW'(3)) >> 2);
  assign frame_ok = (frame_w_q != '0) && (frame_h_q != '0) &&
                    (32'(frame_w_q) <= 32'(MAX_WIDTH)) &&
                    (32'(frame_h_q) <= 32'(MAX_HEIGHT)) &&
                    (32'(used_w) <= 32'(STORE_BYTES));
  assign lvl_ok   = !item_q.gray_level[2];
  assign lvl      = item_q.gray_level[1:0];
  assign in_frame = (DW'(item_q.pos_x) < frame_w_q) && (DW'(item_q.pos_y) < frame_h_q);
  assign rect_ok  = (item_q.rect_width != '0) && (item_q.rect_height != '0) &&
                    ((12'(item_q.pos_x) + 12'(item_q.rect_width)) <= 12'(frame_w_q)) &&
                    ((12'(item_q.pos_y) + 12'(item_q.rect_height)) <= 12'(frame_h_q));

  always_comb begin
    act_ok   = 1'b0;
    act_next = S_DONE;
    if (frame_ok) begin
      case (item_q.action)
        gfe_pkg::ACT_SET: begin
          if (lvl_ok && in_frame) begin
            act_ok   = 1'b1;
            act_next = S_PX_RD;
          end
        end
        gfe_pkg::ACT_GET: begin
          if (in_frame) begin
            act_ok   = 1'b1;
            act_next = S_PX_RD;
          end
        end
        gfe_pkg::ACT_FILL: begin
          if (lvl_ok) begin
            act_ok   = 1'b1;
            act_next = S_FILL;
          end
        end
        gfe_pkg::ACT_RECT: begin
          if (lvl_ok && in_frame && rect_ok) begin
            act_ok   = 1'b1;
            act_next = S_PX_RD;
          end
        end
        gfe_pkg::ACT_SCAN: begin
          act_ok   = 1'b1;
          act_next = S_SCAN_RD;
        end
        default: begin
          act_ok   = 1'b0;
          act_next = S_DONE;
        end
      endcase
    end
  end

  assign shift        = 3'(3'd6 - {pixel_q[1:0], 1'b0});
  assign pix_mask     = 8'(8'h03 << shift);
  assign fill_pattern = {4{lvl}};
  assign last_col     = (col_q + DW'(1)) == item_q.rect_width;
  assign last_row     = (row_q + DW'(1)) == item_q.rect_height;
  assign byte_gray    = ((ram_rdata ^ (ram_rdata >> 1)) & gfe_pkg::GRAY_MASK) != 8'h00;

  // Memory port.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(pixel_q >> 2);
    ram_wdata = (ram_rdata & ~pix_mask) | (8'(lvl) << shift);
    case (state_q)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = AW'(cnt_q);
        ram_wdata = fill_pattern;
      end
      S_SCAN_RD: begin
        ram_addr = AW'(cnt_q);
      end
      S_PX_WR: begin
        ram_we = (item_q.action != gfe_pkg::ACT_GET);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  gfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign item_i.ready    = (state_q == S_IDLE);
  assign item_fire       = item_i.valid && item_i.ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = res_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      lvl_rd_q    <= '0;
      gray_q      <= 1'b0;
      area_q      <= '0;
      pixel_q     <= '0;
      row_start_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
    end else begin
      if (out_valid_q && result_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_fire) begin
            item_q  <= item_i.payload;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          area_q  <= mul_p;
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          used_q      <= used_w;
          pixel_q     <= mul_p + PW'(item_q.pos_x);
          row_start_q <= mul_p + PW'(item_q.pos_x);
          col_q       <= '0;
          row_q       <= '0;
          cnt_q       <= '0;
          acc_q       <= act_ok;
          lvl_rd_q    <= '0;
          gray_q      <= 1'b0;
          state_q     <= act_next;
        end
        S_PX_RD: begin
          state_q <= S_PX_WR;
        end
        S_PX_WR: begin
          if (item_q.action == gfe_pkg::ACT_GET) begin
            lvl_rd_q <= 2'((ram_rdata >> shift) & 8'h03);
            state_q  <= S_DONE;
          end else if (item_q.action == gfe_pkg::ACT_SET || (last_col && last_row)) begin
            state_q <= S_DONE;
          end else if (last_col) begin
            col_q       <= '0;
            row_q       <= row_q + DW'(1);
            row_start_q <= row_start_q + PW'(frame_w_q);
            pixel_q     <= row_start_q + PW'(frame_w_q);
            state_q     <= S_PX_RD;
          end else begin
            col_q   <= col_q + DW'(1);
            pixel_q <= pixel_q + PW'(1);
            state_q <= S_PX_RD;
          end
        end
        S_FILL: begin
          if ((cnt_q + CW'(1)) == used_q) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (byte_gray) begin
            gray_q  <= 1'b1;
            state_q <= S_DONE;
          end else if ((cnt_q + CW'(1)) == used_q) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || result_o.ready) begin
            res_q.accepted   <= acc_q;
            res_q.read_level <= lvl_rd_q;
            res_q.has_gray   <= gray_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fire_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_fire |=> (state_q == S_CHECK))
    else $error("Accepted transfer did not start the check step.");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.accepted) |-> (res_q.read_level == 2'b00 && !res_q.has_gray))
    else $error("Rejected action carries nonzero result fields.");

  a_level_gray_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.has_gray && res_q.read_level != 2'b00))
    else $error("Result reports both a read level and a gray scan.");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (cnt_q < used_q))
    else $error("Fill address beyond the used store.");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !result_o.ready) |=> (state_q == S_DONE))
    else $error("Pending result overwritten while the receiver stalls.");
`endif

endmodule

`default_nettype wire
